### src/lbf_pkg.sv
`timescale 1ns / 1ps

package lbf_pkg;

    // Command number ranges, decoded from the top down.
    localparam logic [15:0] CMD_EFFECT  = 16'd9000;
    localparam logic [15:0] CMD_SLICE   = 16'd8000;
    localparam logic [15:0] CMD_DELAY   = 16'd7000;
    localparam logic [15:0] CMD_CEILING = 16'd1000;
    localparam logic [7:0]  LEVEL_FULL  = 8'd255;

    // The ramp step is elapsed_ms divided by eight, and at least one.
    localparam int unsigned STEP_SHIFT = 3;

    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    typedef struct packed {
        logic        action;
        logic [15:0] command_value;
        logic [15:0] elapsed_ms;
    } t_lbf_in;

    typedef struct packed {
        logic [7:0] level;
        logic [3:0] effect_index;
        logic [2:0] slice_index;
        logic [9:0] effect_delay;
        logic       effect_changed;
        logic       slice_changed;
        logic       delay_changed;
    } t_lbf_out;

endpackage

### src/lamp_brightness_fade_controller.sv
`timescale 1ns / 1ps

// Lamp brightness fade controller.
// Input channel: i_in_valid / o_in_stall with payload i_in_data. Each transaction
// is either a command (action 0) or a display tick (action 1).
// Output channel: o_out_valid / i_out_stall with payload o_out_data. Every input
// transaction produces exactly one output transaction carrying the state after it.
// Flow: an accepted item is first held in the input register, then its result is
// written into the output register when the stage advances, and it is offered
// from there until the receiver takes it.
// Throughput is one item per cycle when not stalled; the limit is the single
// compare, add and clamp path from the input register through the state update.
// When the receiver stalls, the output register holds its result unchanged and
// the input register takes at most one more item before o_in_stall rises.
// Reset (synchronous, active low) empties both registers and restores the state:
// level 0, target 0, ceiling 255, no switch pending, effect 1, slice 0, delay 0.
module lamp_brightness_fade_controller #(
    parameter int NUM_EFFECTS = 16,
    parameter int NUM_SLICES  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lbf_pkg::t_lbf_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lbf_pkg::t_lbf_out o_out_data
);

    localparam int EW = $clog2(NUM_EFFECTS);
    localparam int SW = (NUM_SLICES > 1) ? $clog2(NUM_SLICES) : 1;

    // Input register
    logic             r_in_valid;
    lbf_pkg::t_lbf_in r_in;

    // Output register
    logic              r_out_valid;
    lbf_pkg::t_lbf_out r_out;
    lbf_pkg::t_lbf_out n_out;

    // Controller state
    logic [7:0]    r_level,   n_level;
    logic [7:0]    r_target,  n_target;
    logic [7:0]    r_ceiling, n_ceiling;
    logic [EW-1:0] r_pending, n_pending;
    logic [EW-1:0] r_effect,  n_effect;
    logic [SW-1:0] r_slice,   n_slice;
    logic [9:0]    r_delay,   n_delay;

    logic advance;
    logic effect_flag, slice_flag, delay_flag;

    logic [15:0] cmd;
    logic [15:0] effect_off, slice_off, delay_off, ceiling_off;

    logic        tk_switch;
    logic [7:0]  tk_target;
    logic [12:0] step_raw, step;
    logic [13:0] up_sum;
    logic [7:0]  gap;
    logic [7:0]  ramp;

    logic [EW+3:0] effect_ext;
    logic [SW+2:0] slice_ext;

    // The stage moves whenever the output register is empty or being drained.
    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign cmd         = r_in.command_value;
    assign effect_off  = cmd - lbf_pkg::CMD_EFFECT;
    assign slice_off   = cmd - lbf_pkg::CMD_SLICE;
    assign delay_off   = cmd - lbf_pkg::CMD_DELAY;
    assign ceiling_off = cmd - lbf_pkg::CMD_CEILING;

    // Tick path: finish a pending switch once the lamp is dark, then ramp.
    assign tk_switch = (r_pending != '0) && (r_level == 8'd0);
    assign tk_target = tk_switch ? lbf_pkg::LEVEL_FULL : r_target;
    assign step_raw  = r_in.elapsed_ms[15:lbf_pkg::STEP_SHIFT];
    assign step      = (step_raw == 13'd0) ? 13'd1 : step_raw;
    assign up_sum    = {6'b0, r_level} + {1'b0, step};
    assign gap       = r_level - tk_target;

    always_comb begin
        if (r_level < tk_target) begin
            ramp = (up_sum > {6'b0, tk_target}) ? tk_target : up_sum[7:0];
        end else if (r_level > tk_target) begin
            // When the step is below the gap it fits in eight bits.
            ramp = ({5'b0, gap} <= step) ? tk_target : r_level - step[7:0];
        end else begin
            ramp = r_level;
        end
    end

    always_comb begin
        n_level     = r_level;
        n_target    = r_target;
        n_ceiling   = r_ceiling;
        n_pending   = r_pending;
        n_effect    = r_effect;
        n_slice     = r_slice;
        n_delay     = r_delay;
        effect_flag = 1'b0;
        slice_flag  = 1'b0;
        delay_flag  = 1'b0;
        if (r_in.action == lbf_pkg::ACT_COMMAND) begin
            priority if (cmd >= lbf_pkg::CMD_EFFECT) begin
                // Effect zero and effects beyond the table are ignored.
                if (effect_off != 16'd0 && effect_off < 16'(NUM_EFFECTS)) begin
                    n_pending = effect_off[EW-1:0];
                    n_target  = 8'd0;
                end
            end else if (cmd >= lbf_pkg::CMD_SLICE) begin
                if (slice_off < 16'(NUM_SLICES)) begin
                    n_slice    = slice_off[SW-1:0];
                    slice_flag = 1'b1;
                end
            end else if (cmd >= lbf_pkg::CMD_DELAY) begin
                n_delay    = delay_off[9:0];
                delay_flag = 1'b1;
            end else if (cmd >= lbf_pkg::CMD_CEILING) begin
                n_ceiling = ceiling_off[7:0];
            end else if (cmd <= {8'b0, lbf_pkg::LEVEL_FULL}) begin
                if (r_pending == '0) begin
                    n_target = cmd[7:0];
                end
            end else begin
                n_level = r_level;
            end
        end else begin
            if (tk_switch) begin
                n_effect    = r_pending;
                n_pending   = '0;
                effect_flag = 1'b1;
            end
            if (ramp > r_ceiling) begin
                n_level  = r_ceiling;
                n_target = r_ceiling;
            end else begin
                n_level  = ramp;
                n_target = tk_target;
            end
        end
    end

    assign effect_ext = {4'b0, n_effect};
    assign slice_ext  = {3'b0, n_slice};

    always_comb begin
        n_out.level          = n_level;
        n_out.effect_index   = effect_ext[3:0];
        n_out.slice_index    = slice_ext[2:0];
        n_out.effect_delay   = n_delay;
        n_out.effect_changed = effect_flag;
        n_out.slice_changed  = slice_flag;
        n_out.delay_changed  = delay_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_level     <= 8'd0;
            r_target    <= 8'd0;
            r_ceiling   <= lbf_pkg::LEVEL_FULL;
            r_pending   <= '0;
            r_effect    <= EW'(1);
            r_slice     <= '0;
            r_delay     <= 10'd0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_level   <= n_level;
                    r_target  <= n_target;
                    r_ceiling <= n_ceiling;
                    r_pending <= n_pending;
                    r_effect  <= n_effect;
                    r_slice   <= n_slice;
                    r_delay   <= n_delay;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

endmodule

### src/lbf_checker.sv
`timescale 1ns / 1ps

module lbf_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input lbf_pkg::t_lbf_in  i_in_data,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input lbf_pkg::t_lbf_out o_out_data
);

    // A stalled output transaction stays offered with the same payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output transaction changed or dropped");

    // Reset empties the output register.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // The input side only backs up behind a full, stalled output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output can drain");

    // One item is either a tick or a command, so change flags never combine.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !((o_out_data.effect_changed && o_out_data.slice_changed)
                       || (o_out_data.effect_changed && o_out_data.delay_changed)
                       || (o_out_data.slice_changed && o_out_data.delay_changed)))
        else $error("more than one change flag in a result");

endmodule

bind lamp_brightness_fade_controller lbf_checker u_lbf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
